FILE: src/pae_pkg.sv
// ----------------------------------------------------------------------------
// pae_pkg
// Shared types and constants of the primitive assembly expander.
// ----------------------------------------------------------------------------
`default_nettype none

package pae_pkg;

	localparam int INDEX_BITS    = 32;
	localparam int CFG_DATA_BITS = 32;
	localparam int CFG_IDX_BITS  = 2;
	localparam int FIFO_DEPTH    = 4;
	localparam int PTR_BITS      = $clog2(FIFO_DEPTH);
	localparam int CNT_BITS      = $clog2(FIFO_DEPTH + 1);

	typedef logic [INDEX_BITS-1:0] index_t;

	typedef enum logic [2:0] {
		MODE_TRI_LIST   = 3'd0,
		MODE_TRI_STRIP  = 3'd1,
		MODE_TRI_FAN    = 3'd2,
		MODE_LINES      = 3'd3,
		MODE_LINE_STRIP = 3'd4,
		MODE_LINE_LOOP  = 3'd5,
		MODE_POINTS     = 3'd6,
		MODE_NONE       = 3'd7
	} mode_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_TOPOLOGY      = 2'd0,
		REG_RESTART_ON    = 2'd1,
		REG_RESTART_VALUE = 2'd2,
		REG_UNUSED        = 2'd3
	} reg_idx_t;

	typedef struct packed {
		mode_t  mode;
		logic   restart_on;
		index_t restart_value;
	} cfg_t;

	typedef struct packed {
		logic [1:0] count;
		logic [1:0] phase;
		logic       odd;
		index_t     first;
		index_t     older;
		index_t     newer;
	} seg_state_t;

	typedef struct packed {
		index_t a;
		index_t b;
		index_t c;
		logic   last;
	} tri_t;

	typedef struct packed {
		logic [1:0] n;
		tri_t       r0;
		tri_t       r1;
	} push_t;

endpackage

`default_nettype wire

FILE: src/primitive_assembly_expander_top.sv
// ----------------------------------------------------------------------------
// primitive_assembly_expander_top
// Vertex index stream to triangle index triples, with primitive restart.
// ----------------------------------------------------------------------------
// The block takes one vertex index per cycle unless stalled and, in the same
// cycle, turns it into zero, one or two triangle triples for a four-entry
// result queue; the output drains one triple per cycle unless stalled. Input
// stall rises only when fewer than two queue entries are free, so a steady
// index stream flows at one index per cycle unless the output stalls. Points
// become (p,p,p) and lines (a,b,b). With restart on, an index equal to the
// restart value closes the segment and is dropped; end_of_draw closes it after
// its index is used. last_of_run marks the final triple of each request.
// Write configuration only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module primitive_assembly_expander_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write,
	input  logic [pae_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [pae_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [pae_pkg::INDEX_BITS-1:0]       vtx_index,
	input  logic                                 end_of_draw,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [pae_pkg::INDEX_BITS-1:0]       corner_a,
	output logic [pae_pkg::INDEX_BITS-1:0]       corner_b,
	output logic [pae_pkg::INDEX_BITS-1:0]       corner_c,
	output logic                                 last_of_run
);

	pae_pkg::cfg_t                 cfg_q;
	pae_pkg::seg_state_t           seg_q;
	pae_pkg::seg_state_t           seg_next;
	pae_pkg::push_t                step_push;
	pae_pkg::push_t                fifo_push;
	pae_pkg::tri_t                 head;
	logic [pae_pkg::CNT_BITS-1:0]  fifo_count;
	logic                          in_take;
	logic                          out_take;

	// Hold off new requests unless two free entries can absorb a worst case.
	assign in_stall = (fifo_count > pae_pkg::CNT_BITS'(pae_pkg::FIFO_DEPTH - 2));
	assign in_take  = in_valid && !in_stall;
	assign out_valid = (fifo_count != '0);
	assign out_take  = out_valid && !out_stall;

	// Configuration registers; an index past the list is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode          <= pae_pkg::MODE_TRI_LIST;
			cfg_q.restart_on    <= 1'b0;
			cfg_q.restart_value <= '1;
		end else if (cfg_write) begin
			case (pae_pkg::reg_idx_t'(cfg_index))
				pae_pkg::REG_TOPOLOGY: begin
					cfg_q.mode <= pae_pkg::mode_t'(cfg_data[2:0]);
				end
				pae_pkg::REG_RESTART_ON: begin
					cfg_q.restart_on <= cfg_data[0];
				end
				pae_pkg::REG_RESTART_VALUE: begin
					cfg_q.restart_value <= cfg_data[pae_pkg::INDEX_BITS-1:0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	// Segment tracking: advance only on an accepted request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q <= '0;
		end else if (in_take) begin
			seg_q <= seg_next;
		end
	end

	pae_assemble u_assemble (
		.cfg          (cfg_q),
		.cur          (seg_q),
		.vtx_index    (vtx_index),
		.end_of_draw  (end_of_draw),
		.nxt          (seg_next),
		.push         (step_push)
	);

	// Drop the step's triangles unless the request is actually taken.
	always_comb begin
		fifo_push = step_push;
		if (!in_take) begin
			fifo_push.n = 2'd0;
		end
	end

	pae_result_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fifo_push),
		.pop    (out_take),
		.head   (head),
		.count  (fifo_count)
	);

	assign corner_a    = head.a;
	assign corner_b    = head.b;
	assign corner_c    = head.c;
	assign last_of_run = head.last;

endmodule

`default_nettype wire

FILE: src/pae_assemble.sv
// ----------------------------------------------------------------------------
// pae_assemble
// Combinational step: one index plus segment state gives the next state and
// up to two triangles.
// ----------------------------------------------------------------------------
`default_nettype none

module pae_assemble (
	input  pae_pkg::cfg_t       cfg,
	input  pae_pkg::seg_state_t cur,
	input  pae_pkg::index_t     vtx_index,
	input  logic                end_of_draw,
	output pae_pkg::seg_state_t nxt,
	output pae_pkg::push_t      push
);

	pae_pkg::seg_state_t upd;
	pae_pkg::tri_t       prim;
	pae_pkg::tri_t       clos;
	logic                prim_ok;
	logic                clos_ok;
	logic                is_restart;
	logic                is_loop;

	assign is_restart = cfg.restart_on && (vtx_index == cfg.restart_value);
	assign is_loop    = (cfg.mode == pae_pkg::MODE_LINE_LOOP);

	always_comb begin
		prim    = '0;
		prim_ok = 1'b0;
		upd     = cur;
		case (cfg.mode)
			pae_pkg::MODE_TRI_LIST: begin
				prim_ok   = (cur.phase == 2'd2);
				prim      = '{cur.older, cur.newer, vtx_index, 1'b0};
				upd.phase = (cur.phase >= 2'd2) ? 2'd0 : cur.phase + 2'd1;
			end
			pae_pkg::MODE_TRI_STRIP: begin
				prim_ok = cur.count[1];
				if (cur.odd) begin
					prim = '{cur.newer, cur.older, vtx_index, 1'b0};
				end else begin
					prim = '{cur.older, cur.newer, vtx_index, 1'b0};
				end
				upd.odd = cur.odd ^ cur.count[1];
			end
			pae_pkg::MODE_TRI_FAN: begin
				prim_ok = cur.count[1];
				prim    = '{cur.first, cur.newer, vtx_index, 1'b0};
			end
			pae_pkg::MODE_LINES: begin
				prim_ok   = (cur.phase == 2'd1);
				prim      = '{cur.newer, vtx_index, vtx_index, 1'b0};
				upd.phase = (cur.phase == 2'd1) ? 2'd0 : 2'd1;
			end
			pae_pkg::MODE_LINE_STRIP, pae_pkg::MODE_LINE_LOOP: begin
				prim_ok = (cur.count != 2'd0);
				prim    = '{cur.newer, vtx_index, vtx_index, 1'b0};
			end
			pae_pkg::MODE_POINTS: begin
				prim_ok = 1'b1;
				prim    = '{vtx_index, vtx_index, vtx_index, 1'b0};
			end
			default: begin
				prim_ok = 1'b0;
			end
		endcase
		if (cur.count == 2'd0) begin
			upd.first = vtx_index;
		end
		if (cur.count != 2'd3) begin
			upd.count = cur.count + 2'd1;
		end
		upd.older = cur.newer;
		upd.newer = vtx_index;
	end

	always_comb begin
		push = '0;
		nxt  = upd;
		clos = '0;
		if (is_restart) begin
			clos_ok = is_loop && cur.count[1];
			clos    = '{cur.newer, cur.first, cur.first, 1'b1};
			nxt     = '0;
			push.n  = {1'b0, clos_ok};
			push.r0 = clos;
		end else begin
			clos_ok = end_of_draw && is_loop && upd.count[1];
			clos    = '{upd.newer, upd.first, upd.first, 1'b1};
			if (end_of_draw) begin
				nxt = '0;
			end
			if (prim_ok) begin
				push.r0      = prim;
				push.r0.last = !clos_ok;
				push.r1      = clos;
				push.n       = clos_ok ? 2'd2 : 2'd1;
			end else begin
				push.r0 = clos;
				push.n  = {1'b0, clos_ok};
			end
		end
	end

endmodule

`default_nettype wire

FILE: src/pae_result_fifo.sv
// ----------------------------------------------------------------------------
// pae_result_fifo
// Small result queue: takes up to two triangles per cycle, hands out one.
// ----------------------------------------------------------------------------
`default_nettype none

module pae_result_fifo (
	input  logic                            clk,
	input  logic                            arst_n,
	input  pae_pkg::push_t                  push,
	input  logic                            pop,
	output pae_pkg::tri_t                   head,
	output logic [pae_pkg::CNT_BITS-1:0]    count
);

	pae_pkg::tri_t                 mem_q [pae_pkg::FIFO_DEPTH];
	logic [pae_pkg::PTR_BITS-1:0]  wptr_q;
	logic [pae_pkg::PTR_BITS-1:0]  rptr_q;
	logic [pae_pkg::CNT_BITS-1:0]  count_q;
	logic [pae_pkg::PTR_BITS-1:0]  wptr_1;

	assign wptr_1 = wptr_q + pae_pkg::PTR_BITS'(1);
	assign head   = mem_q[rptr_q];
	assign count  = count_q;

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wptr_q] <= push.r0;
		end
		if (push.n == 2'd2) begin
			mem_q[wptr_1] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			wptr_q  <= wptr_q + pae_pkg::PTR_BITS'(push.n);
			rptr_q  <= rptr_q + pae_pkg::PTR_BITS'(pop);
			count_q <= count_q + pae_pkg::CNT_BITS'(push.n) - pae_pkg::CNT_BITS'(pop);
		end
	end

endmodule

`default_nettype wire

FILE: src/pae_checker.sv
// ----------------------------------------------------------------------------
// pae_checker
// Port-level assertions for the primitive assembly expander.
// ----------------------------------------------------------------------------
`default_nettype none

module pae_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 in_stall,
	input logic                                 out_valid,
	input logic                                 out_stall,
	input logic [pae_pkg::INDEX_BITS-1:0]       corner_a,
	input logic [pae_pkg::INDEX_BITS-1:0]       corner_b,
	input logic [pae_pkg::INDEX_BITS-1:0]       corner_c,
	input logic                                 last_of_run
);

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(corner_a) && $stable(corner_b)
			&& $stable(corner_c) && $stable(last_of_run))
		else $error("stalled result changed");

	// An empty queue never stalls the input side.
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty result queue");

	// A pair of results is a line edge then a closure: both are (x,y,y).
	a_pair_is_line: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_of_run |-> corner_b == corner_c)
		else $error("non-final result is not a line");

	// The closure is queued with its edge, so it follows at once.
	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_of_run |=> out_valid && last_of_run)
		else $error("second result of a pair missing");

endmodule

bind primitive_assembly_expander_top pae_checker u_pae_checker (.*);

`default_nettype wire

FILE: verif/tb_primitive_assembly_expander_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_primitive_assembly_expander_top
// Self-checking bench for the index-stream to triangle expander. A driver
// offers vertex index requests from a pending queue, a predictor computes
// the triangles each accepted request should cause, and a monitor compares
// every triangle leaving the block against the oldest prediction. Topology
// and restart settings change between phases while the block is idle.
// ----------------------------------------------------------------------------

module tb_primitive_assembly_expander_top;

	localparam int QUIET_LIMIT      = 3000;	// cycles with no handshake at all
	localparam int LONG_HOLD_CYCLES = 80;
	localparam int SETTLE_CYCLES    = 4;
	localparam int RANDOM_ITEMS     = 1650;
	localparam int SHOW_LIMIT       = 10;

	// One entry of the pending queue: an index request, or a marker that
	// makes the driver hold off until every predicted triangle has arrived.
	typedef struct {
		pae_pkg::index_t idx;
		logic            eod;
		logic            drain;
	} index_req_t;

	logic                              clk          = 1'b0;
	logic                              arst_n       = 1'b0;
	logic                              cfg_write    = 1'b0;
	logic [pae_pkg::CFG_IDX_BITS-1:0]  cfg_index    = '0;
	logic [pae_pkg::CFG_DATA_BITS-1:0] cfg_data     = '0;
	logic                              in_valid     = 1'b0;
	logic                              in_stall;
	pae_pkg::index_t                   vtx_index    = '0;
	logic                              end_of_draw  = 1'b0;
	logic                              out_valid;
	logic                              out_stall    = 1'b0;
	pae_pkg::index_t                   corner_a;
	pae_pkg::index_t                   corner_b;
	pae_pkg::index_t                   corner_c;
	logic                              last_of_run;

	primitive_assembly_expander_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.vtx_index    (vtx_index),
		.end_of_draw  (end_of_draw),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.corner_a     (corner_a),
		.corner_b     (corner_b),
		.corner_c     (corner_c),
		.last_of_run  (last_of_run)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Bench-side copy of the configuration and the segment state
	// ------------------------------------------------------------------
	pae_pkg::mode_t  topo        = pae_pkg::MODE_TRI_LIST;
	bit              restart_en  = 1'b0;
	pae_pkg::index_t restart_idx = '1;

	logic [1:0]      seg_count;
	logic [1:0]      list_phase;
	bit              strip_odd;
	pae_pkg::index_t seg_first;
	pae_pkg::index_t older;
	pae_pkg::index_t newer;

	index_req_t      pending[$];	// requests waiting to be offered
	pae_pkg::tri_t   tri_expect[$];	// predicted triangles, oldest first
	pae_pkg::tri_t   run_tris[$];	// triangles caused by the request being predicted

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit long_hold_req = 1'b0;
	bit draining      = 1'b0;

	int n_queued     = 0;
	int n_accepted   = 0;
	int n_restarts   = 0;
	int n_closures   = 0;
	int n_checked    = 0;
	int n_errors     = 0;
	int n_shown      = 0;
	int n_phases     = 0;
	int quiet_cycles = 0;

	function automatic pae_pkg::tri_t make_tri(pae_pkg::index_t a, pae_pkg::index_t b,
		pae_pkg::index_t c);
		pae_pkg::tri_t t;
		t.a    = a;
		t.b    = b;
		t.c    = c;
		t.last = 1'b0;
		return t;
	endfunction

	function automatic void add_run_tri(pae_pkg::tri_t t);
		run_tris.insert(run_tris.size(), t);
	endfunction

	function automatic void clear_segment();
		seg_count  = '0;
		list_phase = '0;
		strip_odd  = 1'b0;
		seg_first  = '0;
		older      = '0;
		newer      = '0;
	endfunction

	// End of segment: a line loop with two or more indices closes back to
	// its first index.
	function automatic void close_segment();
		if (topo == pae_pkg::MODE_LINE_LOOP && seg_count >= 2'd2) begin
			add_run_tri(make_tri(newer, seg_first, seg_first));
			n_closures++;
		end
		clear_segment();
	endfunction

	// Work out every triangle one accepted index request causes and append
	// them to the expectation queue, marking the last one of the request.
	function automatic void predict_index(pae_pkg::index_t idx, logic eod);
		pae_pkg::tri_t t;
		run_tris.delete();
		if (restart_en && idx == restart_idx) begin
			// restart index is dropped; only a loop closure may come out
			n_restarts++;
			close_segment();
		end else begin
			case (topo)
				pae_pkg::MODE_TRI_LIST: begin
					if (list_phase == 2'd2)
						add_run_tri(make_tri(older, newer, idx));
					list_phase = (list_phase >= 2'd2) ? 2'd0 : list_phase + 2'd1;
				end
				pae_pkg::MODE_TRI_STRIP: begin
					if (seg_count >= 2'd2) begin
						// winding flips on every other triangle of the strip
						if (!strip_odd)
							add_run_tri(make_tri(older, newer, idx));
						else
							add_run_tri(make_tri(newer, older, idx));
						strip_odd = ~strip_odd;
					end
				end
				pae_pkg::MODE_TRI_FAN: begin
					if (seg_count >= 2'd2)
						add_run_tri(make_tri(seg_first, newer, idx));
				end
				pae_pkg::MODE_LINES: begin
					if (list_phase == 2'd1)
						add_run_tri(make_tri(newer, idx, idx));
					list_phase = (list_phase == 2'd1) ? 2'd0 : 2'd1;
				end
				pae_pkg::MODE_LINE_STRIP, pae_pkg::MODE_LINE_LOOP: begin
					if (seg_count >= 2'd1)
						add_run_tri(make_tri(newer, idx, idx));
				end
				pae_pkg::MODE_POINTS: begin
					add_run_tri(make_tri(idx, idx, idx));
				end
				default: begin
					// unknown topology: track the segment, emit nothing
				end
			endcase
			if (seg_count == 2'd0)
				seg_first = idx;
			if (seg_count != 2'd3)
				seg_count = seg_count + 2'd1;
			older = newer;
			newer = idx;
			if (eod)
				close_segment();
		end
		if (eod && run_tris.size() == 0)
			clear_segment();
		if (run_tris.size() > 0) begin
			t = run_tris[run_tris.size() - 1];
			t.last = 1'b1;
			run_tris[run_tris.size() - 1] = t;
		end
		foreach (run_tris[i])
			tri_expect.insert(tri_expect.size(), run_tris[i]);
	endfunction

	// ------------------------------------------------------------------
	// Driver: offer pending requests, predict on every accepted one
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		index_req_t req;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				predict_index(vtx_index, end_of_draw);
				n_accepted++;
			end
			if (draining && tri_expect.size() == 0)
				draining = 1'b0;
			// a stalled request holds its payload; otherwise pick the next one
			if (!in_valid || !in_stall) begin
				if (pending.size() > 0 && pending[0].drain) begin
					void'(pending.pop_front());
					draining = 1'b1;
				end
				if (!draining && pending.size() > 0 &&
				    $urandom_range(99) >= send_idle_pct) begin
					req = pending.pop_front();
					in_valid     <= 1'b1;
					vtx_index    <= req.idx;
					end_of_draw  <= req.eod;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: check each accepted triangle, drive random or long stalls
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		pae_pkg::tri_t want;
		pae_pkg::tri_t got;
		int            hold_left;
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				got.a    = corner_a;
				got.b    = corner_b;
				got.c    = corner_c;
				got.last = last_of_run;
				n_checked++;
				if (tri_expect.size() == 0) begin
					n_errors++;
					if (n_shown < SHOW_LIMIT) begin
						n_shown++;
						$display("ERROR @%0t: unexpected triangle (%h,%h,%h) last=%b",
							$realtime, got.a, got.b, got.c, got.last);
					end
				end else begin
					want = tri_expect.pop_front();
					if (got.a !== want.a || got.b !== want.b || got.c !== want.c ||
					    got.last !== want.last) begin
						n_errors++;
						if (n_shown < SHOW_LIMIT) begin
							n_shown++;
							$display("ERROR @%0t: expected (%h,%h,%h) last=%b, got (%h,%h,%h) last=%b",
								$realtime, want.a, want.b, want.c, want.last,
								got.a, got.b, got.c, got.last);
						end
					end
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (long_hold_req) begin
				// hold off long enough for the result queue to fill and push back
				long_hold_req = 1'b0;
				hold_left = LONG_HOLD_CYCLES - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: drop the run if no handshake moves for too long
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n || cfg_write || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("ERROR: no handshake for %0d cycles, %0d triangles still expected",
				quiet_cycles, tri_expect.size());
			$display("tb: failure");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	function automatic void push_index(pae_pkg::index_t idx, logic eod);
		index_req_t req;
		req.idx   = idx;
		req.eod   = eod;
		req.drain = 1'b0;
		pending.insert(pending.size(), req);
		n_queued++;
	endfunction

	// Mostly small indices so strips and fans share values, plus the
	// extremes, full-width random values and the restart index.
	function automatic pae_pkg::index_t pick_index();
		int unsigned r;
		r = $urandom_range(99);
		if (restart_en && r < 6)
			return restart_idx;
		if (r < 12)
			return r[0] ? '1 : '0;
		if (r < 70)
			return pae_pkg::index_t'($urandom_range(255));
		return pae_pkg::index_t'($urandom);
	endfunction

	// Well-formed draws of random length with random content, and some
	// loose requests with a random end-of-draw bit in between.
	function automatic void queue_draws(int n);
		int made;
		int len;
		made = 0;
		while (made < n) begin
			if ($urandom_range(99) < 80) begin
				len = ($urandom_range(9) == 0) ? $urandom_range(10, 20) : $urandom_range(0, 7);
				for (int k = 0; k < len; k++)
					push_index(pick_index(), 1'b0);
				// close by restart index (with or without end of draw) or by end of draw
				if (restart_en && $urandom_range(3) == 0)
					push_index(restart_idx, $urandom_range(1) != 0);
				else
					push_index(pick_index(), 1'b1);
				made += len + 1;
			end else begin
				push_index(pick_index(), $urandom_range(1) != 0);
				made++;
			end
		end
	endfunction

	// Wait until nothing is offered or expected, then let the block settle.
	task automatic wait_idle();
		@(negedge clk);
		while (pending.size() != 0 || in_valid || draining || tri_expect.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Keep write enable high across back-to-back writes; end_writes drops it.
	task automatic write_reg(pae_pkg::reg_idx_t ri, logic [pae_pkg::CFG_DATA_BITS-1:0] data);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= ri;
		cfg_data  <= data;
		case (ri)
			pae_pkg::REG_TOPOLOGY:      topo = pae_pkg::mode_t'(data[2:0]);
			pae_pkg::REG_RESTART_ON:    restart_en = data[0];
			pae_pkg::REG_RESTART_VALUE: restart_idx = pae_pkg::index_t'(data);
			default: ;
		endcase
	endtask

	task automatic write_mode(pae_pkg::mode_t m);
		write_reg(pae_pkg::REG_TOPOLOGY, pae_pkg::CFG_DATA_BITS'(m));
	endtask

	task automatic end_writes();
		@(posedge clk);
		cfg_write <= 1'b0;
		@(negedge clk);
		n_phases++;
	endtask

	task automatic randomize_config();
		logic [pae_pkg::CFG_DATA_BITS-1:0] value;
		write_reg(pae_pkg::REG_TOPOLOGY, $urandom_range(7));
		if ($urandom_range(1))
			write_reg(pae_pkg::REG_RESTART_ON, ($urandom_range(99) < 70) ? 1 : 0);
		if ($urandom_range(1)) begin
			case ($urandom_range(3))
				0: value = '0;
				1: value = '1;
				2: value = $urandom_range(255);
				default: value = $urandom;
			endcase
			write_reg(pae_pkg::REG_RESTART_VALUE, value);
		end
		end_writes();
	endtask

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		int directed_items;
		int random_done;
		int phase_items;
		int phase_no;
		index_req_t marker;

		clear_segment();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_idle_pct = 24;
		recv_idle_pct = 63;

		// Reset settings: triangle list, restart off, all-ones index is plain.
		push_index('0, 1'b0);
		push_index('1, 1'b0);
		push_index(pae_pkg::index_t'(1), 1'b1);
		wait_idle();

		// Line loop with restart at zero: restart on an empty segment, restart
		// after one index (no closure), then restart together with end of draw.
		write_reg(pae_pkg::REG_RESTART_ON, 1);
		write_reg(pae_pkg::REG_RESTART_VALUE, 0);
		write_mode(pae_pkg::MODE_LINE_LOOP);
		end_writes();
		push_index('0, 1'b0);
		push_index(pae_pkg::index_t'(5), 1'b0);
		push_index('0, 1'b0);
		push_index(pae_pkg::index_t'(7), 1'b0);
		push_index(pae_pkg::index_t'(8), 1'b0);
		push_index('0, 1'b1);
		wait_idle();

		// Strip: winding alternates.
		write_mode(pae_pkg::MODE_TRI_STRIP);
		end_writes();
		push_index(pae_pkg::index_t'(1), 1'b0);
		push_index(pae_pkg::index_t'(2), 1'b0);
		push_index(pae_pkg::index_t'(3), 1'b0);
		push_index(pae_pkg::index_t'(4), 1'b1);
		wait_idle();

		// Fan left open, then switch to line list mid-segment.
		write_mode(pae_pkg::MODE_TRI_FAN);
		end_writes();
		push_index(pae_pkg::index_t'(10), 1'b0);
		push_index(pae_pkg::index_t'(11), 1'b0);
		push_index(pae_pkg::index_t'(12), 1'b0);
		push_index(pae_pkg::index_t'(13), 1'b0);
		wait_idle();
		write_mode(pae_pkg::MODE_LINES);
		end_writes();
		push_index(pae_pkg::index_t'(14), 1'b0);
		push_index(pae_pkg::index_t'(15), 1'b1);
		wait_idle();

		write_mode(pae_pkg::MODE_POINTS);
		end_writes();
		push_index('1, 1'b1);
		wait_idle();

		// Unknown topology: end of draw with nothing emitted.
		write_mode(pae_pkg::MODE_NONE);
		end_writes();
		push_index(pae_pkg::index_t'(3), 1'b0);
		push_index(pae_pkg::index_t'(4), 1'b1);
		wait_idle();

		write_reg(pae_pkg::REG_RESTART_ON, 0);
		write_mode(pae_pkg::MODE_LINE_STRIP);
		end_writes();
		push_index(pae_pkg::index_t'(1), 1'b0);
		push_index(pae_pkg::index_t'(2), 1'b0);
		push_index(pae_pkg::index_t'(3), 1'b1);
		wait_idle();

		// Random phases: idling schedule advances by thirds of the item budget.
		directed_items = n_queued;
		phase_no = 0;
		random_done = 0;
		while (random_done < RANDOM_ITEMS) begin
			if (random_done < RANDOM_ITEMS / 3) begin
				send_idle_pct = 24;
				recv_idle_pct = 63;
			end else if (random_done < 2 * RANDOM_ITEMS / 3) begin
				send_idle_pct = 63;
				recv_idle_pct = 24;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			randomize_config();
			if (phase_no % 9 == 2)
				long_hold_req = 1'b1;
			phase_items = $urandom_range(30, 90);
			if (phase_no % 9 == 5) begin
				// stop offering halfway until everything predicted has drained
				queue_draws(phase_items / 2);
				marker.idx   = '0;
				marker.eod   = 1'b0;
				marker.drain = 1'b1;
				pending.insert(pending.size(), marker);
				queue_draws(phase_items / 2);
			end else begin
				queue_draws(phase_items);
			end
			phase_no++;
			wait_idle();
			random_done = n_queued - directed_items;
		end

		repeat (10) @(negedge clk);
		$display("summary: %0d index requests over %0d settings, %0d restarts, %0d loop closures",
			n_accepted, n_phases, n_restarts, n_closures);
		$display("summary: %0d triangles compared, %0d mismatches", n_checked, n_errors);
		if (n_errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

FILE: filelist.f
src/pae_pkg.sv
src/pae_assemble.sv
src/pae_result_fifo.sv
src/primitive_assembly_expander_top.sv
src/pae_checker.sv
verif/tb_primitive_assembly_expander_top.sv
